### rtl/tlbfl_pkg.sv
// Shared definitions for the fully associative translation buffer.
// Holds default sizes, operation and register codes, the controller state and the
// per-cell control struct. No dependencies.
package tlbfl_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int PAGE_BITS_DEF  = 20;
   localparam int FRAME_BITS_DEF = 20;
   localparam int AGE_BITS_DEF   = 16;

   localparam int               LIMIT_BITS    = 5;
   localparam logic [4:0]       LIMIT_RESET   = 5'd16;
   localparam int               CSR_ADDR_BITS = 3;
   localparam int               CSR_DATA_BITS = 32;
   localparam logic             REG_POLICY    = 1'b0;
   localparam logic             REG_ENTRIES   = 1'b1;
   localparam logic             POLICY_FIFO   = 1'b0;
   localparam logic             POLICY_LRU    = 1'b1;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic age_up;
      logic age_down;
      logic set_entry;
      logic set_age;
   } cell_ctl_type;

endpackage

### rtl/tlbfl_cell.sv
// One buffer slot: page, frame and age, with a local page compare and one stage
// of the oldest-entry search chain. Depends on tlbfl_pkg.
module tlbfl_cell #(
   parameter int PAGE_BITS  = tlbfl_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS = tlbfl_pkg::FRAME_BITS_DEF,
   parameter int AGE_BITS   = tlbfl_pkg::AGE_BITS_DEF,
   parameter int IDX_BITS   = 4,
   parameter logic [IDX_BITS-1:0] INDEX = '0
) (
   input  logic                       clock,
   input  logic                       filled,
   input  logic                       sel,
   input  tlbfl_pkg::cell_ctl_type    ctl,
   input  logic [PAGE_BITS-1:0]       key,
   input  logic [PAGE_BITS-1:0]       wr_page,
   input  logic [FRAME_BITS-1:0]      wr_frame,
   input  logic [AGE_BITS-1:0]        wr_age,
   input  logic [AGE_BITS-1:0]        prev_age,
   input  logic [IDX_BITS-1:0]        prev_idx,
   output logic [AGE_BITS-1:0]        cand_age,
   output logic [IDX_BITS-1:0]        cand_idx,
   output logic                       match,
   output logic                       age_zero,
   output logic [FRAME_BITS-1:0]      frame
);
   import tlbfl_pkg::*;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   logic [PAGE_BITS-1:0]  page_ff,     page_in;
   logic [FRAME_BITS-1:0] frame_ff,    frame_in;
   logic [AGE_BITS-1:0]   age_ff,      age_in;
   logic [AGE_BITS-1:0]   cand_age_ff, cand_age_in;
   logic [IDX_BITS-1:0]   cand_idx_ff, cand_idx_in;

   always_comb begin
      page_in  = page_ff;
      frame_in = frame_ff;
      age_in   = age_ff;
      if (sel && ctl.set_entry) begin
         page_in  = wr_page;
         frame_in = wr_frame;
      end
      if (sel && ctl.set_age) begin
         age_in = wr_age;
      end else if (filled) begin
         if (ctl.age_up && age_ff != AGE_MAX) begin
            age_in = age_ff + AGE_BITS'(1);
         end else if (ctl.age_down && age_ff != '0) begin
            age_in = age_ff - AGE_BITS'(1);
         end
      end
      // take over the candidate on equal age so the highest slot wins
      if (filled && age_ff >= prev_age) begin
         cand_age_in = age_ff;
         cand_idx_in = INDEX;
      end else begin
         cand_age_in = prev_age;
         cand_idx_in = prev_idx;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      frame_ff    <= frame_in;
      age_ff      <= age_in;
      cand_age_ff <= cand_age_in;
      cand_idx_ff <= cand_idx_in;
   end

   assign cand_age = cand_age_ff;
   assign cand_idx = cand_idx_ff;
   assign match    = filled && (page_ff == key);
   assign age_zero = filled && (age_ff == '0);
   assign frame    = frame_ff;

endmodule

### rtl/tlb_fifo_lru_replacement.sv
// Top level of the fully associative translation buffer with FIFO or LRU replacement.
// Instantiates a row of tlbfl_cell slots and the controller. Depends on tlbfl_pkg.
//
// Use: an operation enters on the req_ stream (tuser opcode: lookup, insert, flush;
// tdata page and frame) and returns exactly one transaction on the rsp_ stream
// (tuser hit, tdata frame of the hit slot or zero). The csr_ port holds the policy
// (0 FIFO, 1 LRU) and the number of slots that may be filled; write it only while idle.
// Flow: one operation at a time; it is taken in ST_IDLE and completed in ST_EXEC,
// and the next is taken only after that. An LRU insert into a full buffer waits
// for the oldest-entry search, which ripples one slot per cycle through the cell
// row; the search count restarts whenever an operation completes.
// Reset: the buffer is empty, the FIFO turn count is zero, policy FIFO, limit 16.
// Stall: the result waits in an output register; a new operation is still taken,
// but it completes only once the waiting result has been taken.
module tlb_fifo_lru_replacement #(
   parameter int ENTRIES    = tlbfl_pkg::ENTRIES_DEF,
   parameter int PAGE_BITS  = tlbfl_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS = tlbfl_pkg::FRAME_BITS_DEF,
   parameter int AGE_BITS   = tlbfl_pkg::AGE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // [PAGE_BITS-1:0] page, then frame, zero fill to bytes
   input  logic [((PAGE_BITS+FRAME_BITS+7)/8)*8-1:0]   req_tdata,
   // [1:0] opcode
   input  logic [1:0]                                  req_tuser,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // [FRAME_BITS-1:0] frame_out, zero fill to bytes
   output logic [((FRAME_BITS+7)/8)*8-1:0]             rsp_tdata,
   // [0] hit
   output logic                                        rsp_tuser,
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [tlbfl_pkg::CSR_ADDR_BITS-1:0]         csr_paddr,
   input  logic [tlbfl_pkg::CSR_DATA_BITS-1:0]         csr_pwdata,
   output logic [tlbfl_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                        csr_pready
);
   import tlbfl_pkg::*;

   localparam int RSP_BITS = ((FRAME_BITS + 7) / 8) * 8;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LIM_BITS = (LIMIT_BITS > CNT_BITS) ? LIMIT_BITS : CNT_BITS;
   localparam int SAT_BITS = ((CNT_BITS > AGE_BITS) ? CNT_BITS : AGE_BITS) + 1;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic                  policy_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [CNT_BITS-1:0]   filled_count_ff, filled_count_in;
   logic [CNT_BITS-1:0]   turn_ff, turn_in;
   logic [CNT_BITS-1:0]   scan_cnt_ff, scan_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;

   logic [ENTRIES-1:0]    filled_vec, match_vec, zero_vec, sel_vec;
   logic [ENTRIES-1:0]    match_oh, zero_oh, fifo_oh, free_oh, lru_oh;
   logic [AGE_BITS-1:0]   cand_age [ENTRIES];
   logic [IDX_BITS-1:0]   cand_idx [ENTRIES];
   logic [FRAME_BITS-1:0] cell_frame [ENTRIES];
   cell_ctl_type          ctl;
   logic [AGE_BITS-1:0]   wr_age;
   logic [FRAME_BITS-1:0] hit_frame;
   logic                  hit;
   logic [LIM_BITS-1:0]   lim_ext, limit;
   logic                  has_free, lru_full, scan_ready, out_free, commit, csr_wr;
   logic [AGE_BITS-1:0]   turn_sat, turn_dec_sat;
   logic [CNT_BITS-1:0]   turn_dec;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         logic [AGE_BITS-1:0] prev_age;
         logic [IDX_BITS-1:0] prev_idx;
         if (g == 0) begin : g_seed
            assign prev_age = '0;
            assign prev_idx = '0;
         end else begin : g_link
            assign prev_age = cand_age[g-1];
            assign prev_idx = cand_idx[g-1];
         end
         assign filled_vec[g] = CNT_BITS'(g) < filled_count_ff;
         assign free_oh[g]    = filled_count_ff == CNT_BITS'(g);
         assign lru_oh[g]     = cand_idx[ENTRIES-1] == IDX_BITS'(g);
         tlbfl_cell #(
            .PAGE_BITS  (PAGE_BITS),
            .FRAME_BITS (FRAME_BITS),
            .AGE_BITS   (AGE_BITS),
            .IDX_BITS   (IDX_BITS),
            .INDEX      (IDX_BITS'(g))
         ) u_cell (
            .clock    (clock),
            .filled   (filled_vec[g]),
            .sel      (sel_vec[g]),
            .ctl      (ctl),
            .key      (page_ff),
            .wr_page  (page_ff),
            .wr_frame (frame_ff),
            .wr_age   (wr_age),
            .prev_age (prev_age),
            .prev_idx (prev_idx),
            .cand_age (cand_age[g]),
            .cand_idx (cand_idx[g]),
            .match    (match_vec[g]),
            .age_zero (zero_vec[g]),
            .frame    (cell_frame[g])
         );
      end
   endgenerate

   assign match_oh = match_vec & (~match_vec + ENTRIES'(1));
   assign zero_oh  = zero_vec & (~zero_vec + ENTRIES'(1));
   assign fifo_oh  = (zero_vec == '0) ? ENTRIES'(1) : zero_oh;
   assign hit      = match_vec != '0;

   always_comb begin
      hit_frame = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_frame = hit_frame | (cell_frame[i] & {FRAME_BITS{match_oh[i]}});
      end
   end

   assign lim_ext      = LIM_BITS'(limit_ff);
   assign limit        = (lim_ext < LIM_BITS'(ENTRIES)) ? lim_ext : LIM_BITS'(ENTRIES);
   assign has_free     = LIM_BITS'(filled_count_ff) < limit;
   assign turn_dec     = turn_ff - CNT_BITS'(1);
   assign turn_sat     = (SAT_BITS'(turn_ff) > SAT_BITS'(AGE_MAX)) ?
                         AGE_MAX : AGE_BITS'(turn_ff);
   assign turn_dec_sat = (turn_ff == '0) ? '0 :
                         ((SAT_BITS'(turn_dec) > SAT_BITS'(AGE_MAX)) ?
                          AGE_MAX : AGE_BITS'(turn_dec));

   assign lru_full   = (op_ff == OP_INSERT) && !has_free && (filled_count_ff != '0) &&
                       (policy_ff == POLICY_LRU);
   assign scan_ready = scan_cnt_ff == CNT_BITS'(ENTRIES);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_EXEC) && out_free && !(lru_full && !scan_ready);

   always_comb begin
      state_in        = state_ff;
      filled_count_in = filled_count_ff;
      turn_in         = turn_ff;
      scan_cnt_in     = scan_ready ? scan_cnt_ff : scan_cnt_ff + CNT_BITS'(1);
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      ctl             = '0;
      sel_vec         = '0;
      wr_age          = '0;
      req_tready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               scan_cnt_in  = '0;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_frame_in = '0;
               case (op_ff)
                  OP_LOOKUP: begin
                     rsp_hit_in   = hit;
                     rsp_frame_in = hit_frame;
                     if (hit && policy_ff == POLICY_LRU) begin
                        ctl.age_up  = 1'b1;
                        ctl.set_age = 1'b1;
                        sel_vec     = match_oh;
                     end
                  end
                  OP_INSERT: begin
                     if (has_free) begin
                        ctl.set_entry   = 1'b1;
                        ctl.set_age     = 1'b1;
                        sel_vec         = free_oh;
                        filled_count_in = filled_count_ff + CNT_BITS'(1);
                        if (policy_ff == POLICY_FIFO) begin
                           wr_age = turn_sat;
                           if (turn_ff < CNT_BITS'(ENTRIES)) begin
                              turn_in = turn_ff + CNT_BITS'(1);
                           end
                        end else begin
                           ctl.age_up = 1'b1;
                        end
                     end else if (filled_count_ff != '0) begin
                        ctl.set_entry = 1'b1;
                        ctl.set_age   = 1'b1;
                        if (policy_ff == POLICY_FIFO) begin
                           ctl.age_down = 1'b1;
                           sel_vec      = fifo_oh;
                           wr_age       = turn_dec_sat;
                        end else begin
                           ctl.age_up = 1'b1;
                           sel_vec    = lru_oh;
                        end
                     end
                  end
                  OP_FLUSH: begin
                     filled_count_in = '0;
                     turn_in         = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         filled_count_ff <= '0;
         turn_ff         <= '0;
         scan_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         filled_count_ff <= filled_count_in;
         turn_ff         <= turn_in;
         scan_cnt_ff     <= scan_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         page_ff  <= req_tdata[PAGE_BITS-1:0];
         frame_ff <= req_tdata[PAGE_BITS +: FRAME_BITS];
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIFO;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[CSR_ADDR_BITS-1] == REG_POLICY) begin
            policy_ff <= csr_pwdata[0];
         end else begin
            limit_ff <= csr_pwdata[LIMIT_BITS-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == REG_ENTRIES) ?
                       CSR_DATA_BITS'(limit_ff) : CSR_DATA_BITS'(policy_ff);
   assign csr_pready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_frame_ff);
   assign rsp_tuser  = rsp_hit_ff;

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("completed transaction did not reach the output register");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_count_ff <= CNT_BITS'(ENTRIES))
      else $error("fill count beyond buffer size");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !commit) |=> (state_ff == ST_EXEC && $stable(op_ff) &&
                                            $stable(page_ff)))
      else $error("pending transaction lost before completion");

endmodule
